// ----- hdl/fmcr_pkg.sv -----
package fmcr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] START_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0] STOP_BYTE   = 8'hFE;
  localparam logic [BYTE_W-1:0] SIGN_OFFSET = 8'd128;

  localparam logic [SCALE_W-1:0] DUTY_SCALE_RST = 8'd80;
  localparam logic [DUTY_W-1:0]  DUTY_LIMIT_RST = 16'd10000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 1'd1;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              dir_upd;
    logic              dir;
  } drive_t;

  // Offset-binary command byte to sign-magnitude drive. A centered byte
  // gives zero duty and leaves the direction alone.
  function automatic drive_t fmcr_drive(input logic [BYTE_W-1:0]  raw,
                                        input logic [SCALE_W-1:0] scale,
                                        input logic [DUTY_W-1:0]  limit);
    drive_t             res;
    logic [BYTE_W-1:0]  mag;
    logic [DUTY_W-1:0]  prod;
    res = '0;
    mag = '0;
    if (raw > SIGN_OFFSET) begin
      mag         = raw - SIGN_OFFSET;
      res.dir_upd = 1'b1;
      res.dir     = 1'b1;
    end else if (raw < SIGN_OFFSET) begin
      mag         = SIGN_OFFSET - raw;
      res.dir_upd = 1'b1;
      res.dir     = 1'b0;
    end
    prod     = DUTY_W'(mag) * DUTY_W'(scale);
    res.duty = (prod > limit) ? limit : prod;
    return res;
  endfunction

endpackage

// ----- hdl/framed_motor_command_receiver.sv -----
// Framed motor command receiver. The in_ channel carries one serial byte
// per transaction. Frames are a 0xFF start byte, four data bytes and a 0xFE
// stop byte; any 0xFF restarts the frame, and a wrong stop byte drops the
// frame without a result. Each well-ended frame produces one transaction on
// the out_ channel with the duty and direction of both motors, taken from
// data bytes one and four. The cfg_ channel writes duty_scale (index 0) and
// duty_limit (index 1); it is always ready and is meant to be used only
// while the block is idle.
//
// Throughput is one byte per cycle while in_ready is high. Parsing happens
// at the edge that accepts the byte; a completed frame is held in one
// intermediate register where the 8x8 duty multiply and the limit compare
// are done, and the result lands in the output register. When the receiver
// stalls out_ready, the output register and the intermediate register still
// absorb one frame each; in_ready drops only while both are occupied and the
// output is not taken.
//
// Reset (synchronous, rst_n low) idles the parser, empties both pipeline
// registers, restores duty_scale to 80 and duty_limit to 10000, and sets the
// right direction to reverse and the left direction to forward.
module framed_motor_command_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fmcr_pkg::BYTE_W-1:0]       in_serial_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fmcr_pkg::DUTY_W-1:0]       out_right_duty,
  output logic [fmcr_pkg::DUTY_W-1:0]       out_left_duty,
  output logic                              out_right_forward,
  output logic                              out_left_forward,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fmcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmcr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fmcr_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_DATA1,
    ST_DATA2,
    ST_DATA3,
    ST_DATA4,
    ST_STOP
  } frame_state_t;

  frame_state_t         state_r, state_nxt;
  logic [BYTE_W-1:0]    right_byte_r, right_byte_nxt;
  logic [BYTE_W-1:0]    left_byte_r, left_byte_nxt;

  // Completed-frame register between the parser and the drive math.
  logic                 s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0]    s1_right_r, s1_right_nxt;
  logic [BYTE_W-1:0]    s1_left_r, s1_left_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]    right_duty_r, right_duty_nxt;
  logic [DUTY_W-1:0]    left_duty_r, left_duty_nxt;
  logic                 right_dir_r, right_dir_nxt;
  logic                 left_dir_r, left_dir_nxt;

  logic [SCALE_W-1:0]   duty_scale_r, duty_scale_nxt;
  logic [DUTY_W-1:0]    duty_limit_r, duty_limit_nxt;

  logic                 in_fire;
  logic                 frame_done;
  logic                 out_free;
  logic                 s1_take;
  drive_t               right_drv;
  drive_t               left_drv;

  // The output register frees up when empty or taken this cycle; the frame
  // register moves forward whenever the output register is free.
  assign out_free  = !out_valid_r || out_ready;
  assign s1_take   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign frame_done = in_fire && (state_r == ST_STOP) && (in_serial_byte == STOP_BYTE);

  assign right_drv = fmcr_drive(s1_right_r, duty_scale_r, duty_limit_r);
  assign left_drv  = fmcr_drive(s1_left_r, duty_scale_r, duty_limit_r);

  always_comb begin
    state_nxt      = state_r;
    right_byte_nxt = right_byte_r;
    left_byte_nxt  = left_byte_r;
    if (in_fire) begin
      unique case (state_r)
        ST_DATA1: begin
          right_byte_nxt = in_serial_byte;
          state_nxt      = ST_DATA2;
        end
        ST_DATA2: state_nxt = ST_DATA3;
        ST_DATA3: state_nxt = ST_DATA4;
        ST_DATA4: begin
          left_byte_nxt = in_serial_byte;
          state_nxt     = ST_STOP;
        end
        default:  state_nxt = ST_WAIT;
      endcase
      // A start byte restarts the frame from any position.
      if (in_serial_byte == START_BYTE) begin
        state_nxt = ST_DATA1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_right_nxt = s1_right_r;
    s1_left_nxt  = s1_left_r;
    if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
    if (frame_done) begin
      s1_valid_nxt = 1'b1;
      s1_right_nxt = right_byte_r;
      s1_left_nxt  = left_byte_r;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    right_duty_nxt = right_duty_r;
    left_duty_nxt  = left_duty_r;
    right_dir_nxt  = right_dir_r;
    left_dir_nxt   = left_dir_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_take) begin
      out_valid_nxt  = 1'b1;
      right_duty_nxt = right_drv.duty;
      left_duty_nxt  = left_drv.duty;
      if (right_drv.dir_upd) begin
        right_dir_nxt = right_drv.dir;
      end
      if (left_drv.dir_upd) begin
        left_dir_nxt = left_drv.dir;
      end
    end
  end

  always_comb begin
    duty_scale_nxt = duty_scale_r;
    duty_limit_nxt = duty_limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DUTY_SCALE: duty_scale_nxt = cfg_data[SCALE_W-1:0];
        REG_DUTY_LIMIT: duty_limit_nxt = cfg_data[DUTY_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WAIT;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      right_dir_r  <= 1'b0;
      left_dir_r   <= 1'b1;
      duty_scale_r <= DUTY_SCALE_RST;
      duty_limit_r <= DUTY_LIMIT_RST;
    end else begin
      state_r      <= state_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      right_dir_r  <= right_dir_nxt;
      left_dir_r   <= left_dir_nxt;
      duty_scale_r <= duty_scale_nxt;
      duty_limit_r <= duty_limit_nxt;
    end
    right_byte_r <= right_byte_nxt;
    left_byte_r  <= left_byte_nxt;
    s1_right_r   <= s1_right_nxt;
    s1_left_r    <= s1_left_nxt;
    right_duty_r <= right_duty_nxt;
    left_duty_r  <= left_duty_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_right_duty    = right_duty_r;
  assign out_left_duty     = left_duty_r;
  assign out_right_forward = right_dir_r;
  assign out_left_forward  = left_dir_r;

  // A good stop byte always lands a frame in the intermediate register.
  a_frame_lands: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> s1_valid_r)
    else $error("completed frame was not captured");

  // A held frame waits, unchanged, until the output register takes it.
  a_frame_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_take && !frame_done) |=>
      (s1_valid_r && $stable(s1_right_r) && $stable(s1_left_r)))
    else $error("pending frame lost or changed");

  // A non-start byte while waiting keeps the parser waiting.
  a_wait_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r == ST_WAIT && in_serial_byte != START_BYTE) |=>
      (state_r == ST_WAIT))
    else $error("parser left the wait state without a start byte");

  // Any accepted start byte puts the parser at the first data byte.
  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_serial_byte == START_BYTE) |=> (state_r == ST_DATA1))
    else $error("start byte did not restart the frame");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

// Testbench for the framed motor command receiver. Serial bytes are pushed
// through the in_ channel with random gaps, and results are drained from the
// out_ channel with random back-pressure. A behavioral copy of the frame
// parser runs alongside and queues the motor command that each good frame
// should produce. The result monitor compares every out_ transaction,
// field by field, against the oldest queued command.
module tb_top;
  import fmcr_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_GAP       = 19;
  // Worst legal quiet stretch is a full sender gap plus a full receiver stall,
  // plus the drain pause, so this leaves a wide margin.
  localparam int QUIET_LIMIT   = 2000;
  // The result register lies behind the parser and the intermediate register.
  localparam int SETTLE_CYCLES = 4;
  localparam int TOTAL_BYTES   = 450;
  localparam int PHASE_BYTES   = 60;
  localparam int MAX_REPORTS   = 10;

  // Parser position within a frame, mirroring the block's own sequencing.
  typedef enum logic [2:0] {
    POS_IDLE,
    POS_DATA1,
    POS_DATA2,
    POS_DATA3,
    POS_DATA4,
    POS_STOP
  } frame_pos_t;

  typedef struct {
    logic [DUTY_W-1:0] right_duty;
    logic [DUTY_W-1:0] left_duty;
    logic              right_fwd;
    logic              left_fwd;
  } motor_cmd_t;

  // Every block input starts at a known value.
  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_serial_byte    = '0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic [DUTY_W-1:0]     out_right_duty;
  logic [DUTY_W-1:0]     out_left_duty;
  logic                  out_right_forward;
  logic                  out_left_forward;
  logic                  cfg_valid         = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;

  // Shadow of the parser state and of the two drive registers, starting
  // from their reset values.
  frame_pos_t        frame_pos  = POS_IDLE;
  logic [BYTE_W-1:0] held_right = '0;
  logic [BYTE_W-1:0] held_left  = '0;
  logic              right_dir  = 1'b0;
  logic              left_dir   = 1'b1;
  logic [SCALE_W-1:0] duty_scale = DUTY_SCALE_RST;
  logic [DUTY_W-1:0]  duty_limit = DUTY_LIMIT_RST;

  // Motor commands that the block still owes us, oldest first.
  motor_cmd_t pending_cmds[$];
  motor_cmd_t due_cmd;

  // Idle controls: when a flag is low that side of the block runs flat out.
  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  int ready_hold  = 0;

  int bytes_sent    = 0;
  int cmds_checked  = 0;
  int reg_writes    = 0;
  int config_phases = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  framed_motor_command_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_serial_byte    (in_serial_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_right_duty    (out_right_duty),
    .out_left_duty     (out_left_duty),
    .out_right_forward (out_right_forward),
    .out_left_forward  (out_left_forward),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Offset-binary command byte to PWM compare value. A centered byte has
  // zero magnitude and therefore zero duty; anything else is scaled and
  // clipped at the configured ceiling.
  function automatic logic [DUTY_W-1:0] byte_to_duty(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] mag;
    int unsigned       prod;
    if (raw > SIGN_OFFSET) begin
      mag = raw - SIGN_OFFSET;
    end else begin
      mag = SIGN_OFFSET - raw;
    end
    prod = int'(mag) * int'(duty_scale);
    return (prod > int'(duty_limit)) ? duty_limit : prod[DUTY_W-1:0];
  endfunction

  // Direction follows the sign of the command; a zero command keeps the
  // previous direction.
  function automatic logic steer(input logic [BYTE_W-1:0] raw, input logic old_dir);
    if (raw > SIGN_OFFSET) begin
      return 1'b1;
    end else if (raw < SIGN_OFFSET) begin
      return 1'b0;
    end
    return old_dir;
  endfunction

  // Advance the shadow parser by one accepted byte. A good stop byte queues
  // the motor command that the block must later deliver. Any start byte
  // restarts the frame after the normal handling of its slot.
  task automatic track_byte(input logic [BYTE_W-1:0] b);
    motor_cmd_t cmd;
    case (frame_pos)
      POS_DATA1: begin
        held_right = b;
        frame_pos  = POS_DATA2;
      end
      POS_DATA2: frame_pos = POS_DATA3;
      POS_DATA3: frame_pos = POS_DATA4;
      POS_DATA4: begin
        held_left = b;
        frame_pos = POS_STOP;
      end
      POS_STOP: begin
        if (b == STOP_BYTE) begin
          right_dir      = steer(held_right, right_dir);
          left_dir       = steer(held_left, left_dir);
          cmd.right_duty = byte_to_duty(held_right);
          cmd.left_duty  = byte_to_duty(held_left);
          cmd.right_fwd  = right_dir;
          cmd.left_fwd   = left_dir;
          pending_cmds.push_back(cmd);
        end
        frame_pos = POS_IDLE;
      end
      default: frame_pos = POS_IDLE;
    endcase
    if (b == START_BYTE) begin
      frame_pos = POS_DATA1;
    end
    bytes_sent++;
  endtask

  // Send one serial byte. Valid is left high after the transaction so that
  // a back-to-back byte does not drop it; a later gap or the drain lowers it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_serial_byte <= b;
    do @(posedge clk); while (!in_ready);
    track_byte(b);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] right_cmd,
                            input logic [BYTE_W-1:0] spare_a,
                            input logic [BYTE_W-1:0] spare_b,
                            input logic [BYTE_W-1:0] left_cmd,
                            input logic [BYTE_W-1:0] stop_val);
    send_byte(START_BYTE);
    send_byte(right_cmd);
    send_byte(spare_a);
    send_byte(spare_b);
    send_byte(left_cmd);
    send_byte(stop_val);
  endtask

  // Stop sending and wait until every queued command has come out, then let
  // the block settle so that nothing is still in the output pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both drive registers back to back in one burst. The scale word
  // carries random upper bits that the block has to ignore.
  task automatic set_drive_config(input logic [CFG_DATA_W-1:0] scale_word,
                                  input logic [CFG_DATA_W-1:0] limit_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DUTY_SCALE;
    cfg_data  <= scale_word;
    do @(posedge clk); while (!cfg_ready);
    duty_scale = scale_word[SCALE_W-1:0];
    cfg_index <= REG_DUTY_LIMIT;
    cfg_data  <= limit_word;
    do @(posedge clk); while (!cfg_ready);
    duty_limit = limit_word;
    cfg_valid <= 1'b0;
    reg_writes += 2;
    config_phases++;
  endtask

  // Command bytes lean toward the interesting values: centered, and the two
  // ends of the range that a data slot can hold.
  function automatic logic [BYTE_W-1:0] cmd_byte();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return SIGN_OFFSET;
      1:       return 8'h00;
      2:       return STOP_BYTE;
      default: return 8'($urandom_range(0, 254));
    endcase
  endfunction

  // Filler for the two ignored data slots; a start byte is kept out so the
  // frame stays well formed.
  function automatic logic [BYTE_W-1:0] spare_byte();
    return 8'($urandom_range(0, 254));
  endfunction

  // With reset settings both commands are large enough to hit the duty
  // ceiling, one in each direction. The spare slots hold the stop byte
  // value, which must not end the frame early.
  task automatic test_reset_settings_frame();
    send_frame(8'h00, STOP_BYTE, STOP_BYTE, STOP_BYTE, STOP_BYTE);
  endtask

  // Framing corner cases in one stream: a stray stop byte while idle, a
  // restart in a data slot, a wrong stop byte, a restart in the stop slot,
  // and finally a good frame whose right command is centered, so the right
  // duty is zero and its direction must hold.
  task automatic test_frame_recovery();
    logic [BYTE_W-1:0] stream [20];
    stream = '{STOP_BYTE, START_BYTE, 8'h10, START_BYTE, 8'h90, 8'h01, 8'h02, 8'h70,
               8'h00, START_BYTE, 8'h20, 8'h33, 8'h44, 8'h60, START_BYTE,
               SIGN_OFFSET, 8'h00, STOP_BYTE, 8'h7F, STOP_BYTE};
    foreach (stream[i]) begin
      send_byte(stream[i]);
    end
  endtask

  // Random traffic in phases. Each phase starts from an idle block with a
  // fresh pair of register values (the first few are the extremes) and its
  // own idling pattern. Most of the traffic is well-formed frames; the rest
  // is frames with a bad stop byte, frames cut short by a restart, and
  // random noise bytes.
  task automatic test_random_traffic();
    int phase;
    int phase_start;
    int pick;
    logic [CFG_DATA_W-1:0] scale_word;
    logic [CFG_DATA_W-1:0] limit_word;
    logic [BYTE_W-1:0] bad_stop;
    phase = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      wait_idle();
      scale_word = 16'($urandom_range(0, 65535));
      case (phase)
        0: begin
          scale_word[SCALE_W-1:0] = '0;
          limit_word = 16'hFFFF;
        end
        1: begin
          scale_word[SCALE_W-1:0] = '1;
          limit_word = 16'h0000;
        end
        2: begin
          scale_word[SCALE_W-1:0] = '1;
          limit_word = 16'hFFFF;
        end
        default: begin
          limit_word = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 4000));
        end
      endcase
      set_drive_config(scale_word, limit_word);
      in_gaps_on  = (phase % 4 == 0) || (phase % 4 == 2);
      out_gaps_on = (phase % 4 == 0) || (phase % 4 == 1);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < TOTAL_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_frame(cmd_byte(), spare_byte(), spare_byte(), cmd_byte(), STOP_BYTE);
        end else if (pick < 85) begin
          // Any value but the stop byte, the start byte included.
          bad_stop = 8'($urandom_range(0, 254));
          if (bad_stop == STOP_BYTE) begin
            bad_stop = START_BYTE;
          end
          send_frame(cmd_byte(), spare_byte(), spare_byte(), cmd_byte(), bad_stop);
        end else if (pick < 93) begin
          send_byte(START_BYTE);
          repeat ($urandom_range(0, 3)) send_byte(spare_byte());
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end
      phase++;
    end
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // Result monitor and receiver back-pressure. Outputs are sampled at the
  // edge, before the block updates them, so the values seen are the ones
  // that took part in the transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      cmds_checked++;
      if (pending_cmds.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: unexpected motor command: right %0d/%0b left %0d/%0b", $realtime,
                   out_right_duty, out_right_forward, out_left_duty, out_left_forward);
        end
      end else begin
        due_cmd = pending_cmds.pop_front();
        if (out_right_duty !== due_cmd.right_duty || out_left_duty !== due_cmd.left_duty ||
            out_right_forward !== due_cmd.right_fwd || out_left_forward !== due_cmd.left_fwd) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: motor command mismatch (expected / actual)", $realtime);
            $display("  right_duty %0d / %0d, left_duty %0d / %0d",
                     due_cmd.right_duty, out_right_duty, due_cmd.left_duty, out_left_duty);
            $display("  right_forward %0b / %0b, left_forward %0b / %0b",
                     due_cmd.right_fwd, out_right_forward, due_cmd.left_fwd, out_left_forward);
          end
        end
      end
      ready_hold = out_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    end
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any transaction on any channel resets the count. A long
  // stretch without one means the block has hung or lost a result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d commands still owed",
               $realtime, quiet_cycles, pending_cmds.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_settings_frame();
    test_frame_recovery();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d serial bytes and checked %0d motor commands.", bytes_sent, cmds_checked);
    $display("Made %0d register writes over %0d drive settings; %0d failures.",
             reg_writes, config_phases, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
